// ===== hw/rtl/srcs_pkg.sv =====
// shared types and constants for the sorted range count search block
// no dependencies; used by srcs_ctrl, srcs_dp and the top level of the block
package srcs_pkg;

    // fixed field widths
    localparam int CFG_W = 11;
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int RES_W = 12;

    // request mode codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_point;   // write one point into the store
        logic start_query;  // latch keys and open both search intervals
        logic step;         // run one probe of both searches
        logic emit;         // capture the difference into the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic search_done;  // both search intervals are empty
    } t_status;

endpackage

// ===== hw/rtl/srcs_ram.sv =====
// generic ram: one write port, two read ports with registered read data
// no dependencies
module srcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]                         o_rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hw/rtl/srcs_ctrl.sv =====
// controller: request handshakes, search sequencing and output valid
// depends on srcs_pkg for the command and status structs
module srcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output srcs_pkg::t_cmd    o_cmd,
    input  srcs_pkg::t_status i_status
);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_accept;
    logic   slot_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_accept   = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;

    // commands to the datapath
    always_comb begin
        o_cmd             = '0;
        o_cmd.load_point  = in_accept && (i_mode == srcs_pkg::MODE_LOAD);
        o_cmd.start_query = in_accept && (i_mode == srcs_pkg::MODE_QUERY);
        o_cmd.step        = (r_state == ST_SEARCH);
        o_cmd.emit        = (r_state == ST_SEARCH) && i_status.search_done && slot_free;
    end

    // next state and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.start_query) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (o_cmd.emit) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a query request always opens a search
    a_query_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_query |=> (r_state == ST_SEARCH))
        else $error("query accepted without entering search");

    // a new result only appears after both searches finished
    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_status.search_done))
        else $error("result raised before searches finished");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result emitted into a full output register");

endmodule

// ===== hw/rtl/srcs_dp.sv =====
// datapath: point store, count register, two bound searches and result register
// depends on srcs_pkg and srcs_ram
module srcs_dp #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [srcs_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  srcs_pkg::t_cmd                      i_cmd,
    output srcs_pkg::t_status                   o_status,
    input  logic [srcs_pkg::IDX_W-1:0]          i_load_index,
    input  logic signed [srcs_pkg::VAL_W-1:0]   i_load_value,
    input  logic signed [srcs_pkg::VAL_W-1:0]   i_query_low,
    input  logic signed [srcs_pkg::VAL_W-1:0]   i_query_high,
    output logic signed [srcs_pkg::RES_W-1:0]   o_points_inside
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > srcs_pkg::CFG_W) ? CNT_W : srcs_pkg::CFG_W;

    logic [srcs_pkg::CFG_W-1:0]        r_point_count;
    logic [CMP_W-1:0]                  cfg_ext;
    logic [CMP_W-1:0]                  max_ext;
    logic [CNT_W-1:0]                  n_eff;

    logic signed [srcs_pkg::VAL_W-1:0] r_key_lo;
    logic signed [srcs_pkg::VAL_W-1:0] r_key_hi;

    // search a: lower bound, search b: upper bound; interval is [lo, end)
    logic [CNT_W-1:0] r_lo_a;
    logic [CNT_W-1:0] r_end_a;
    logic [CNT_W-1:0] r_lo_b;
    logic [CNT_W-1:0] r_end_b;
    logic [CNT_W-1:0] n_lo_a;
    logic [CNT_W-1:0] n_end_a;
    logic [CNT_W-1:0] n_lo_b;
    logic [CNT_W-1:0] n_end_b;

    logic [CNT_W:0]   sum_a;
    logic [CNT_W:0]   sum_b;
    logic [CNT_W-1:0] mid_a;
    logic [CNT_W-1:0] mid_b;
    logic [CNT_W:0]   nsum_a;
    logic [CNT_W:0]   nsum_b;
    logic [CNT_W-1:0] nmid_a;
    logic [CNT_W-1:0] nmid_b;

    logic                  done_a;
    logic                  done_b;
    logic                  hit_a;
    logic                  hit_b;
    logic [srcs_pkg::VAL_W-1:0] rdata_a;
    logic [srcs_pkg::VAL_W-1:0] rdata_b;
    logic                  ram_we;

    logic signed [srcs_pkg::RES_W-1:0] r_result;

    // point count register; its value is saturated to the store depth for the searches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    assign cfg_ext = CMP_W'(r_point_count);
    assign max_ext = CMP_W'(MAX_POINTS);
    assign n_eff   = (cfg_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(cfg_ext);

    // point store, loads outside the store are dropped
    assign ram_we = i_cmd.load_point && (32'(i_load_index) < 32'(MAX_POINTS));

    srcs_ram #(
        .WIDTH (srcs_pkg::VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (AW'(i_load_index)),
        .i_wdata   (i_load_value),
        .i_raddr_a (nmid_a[AW-1:0]),
        .o_rdata_a (rdata_a),
        .i_raddr_b (nmid_b[AW-1:0]),
        .o_rdata_b (rdata_b)
    );

    // probe point of the current interval, its data is in the read register
    assign sum_a  = {1'b0, r_lo_a} + {1'b0, r_end_a} - (CNT_W + 1)'(1);
    assign sum_b  = {1'b0, r_lo_b} + {1'b0, r_end_b} - (CNT_W + 1)'(1);
    assign mid_a  = sum_a[CNT_W:1];
    assign mid_b  = sum_b[CNT_W:1];
    assign done_a = (r_lo_a == r_end_a);
    assign done_b = (r_lo_b == r_end_b);
    assign hit_a  = ($signed(rdata_a) >= r_key_lo);
    assign hit_b  = ($signed(rdata_b) > r_key_hi);

    // interval update for one probe of each search
    always_comb begin
        n_lo_a  = r_lo_a;
        n_end_a = r_end_a;
        n_lo_b  = r_lo_b;
        n_end_b = r_end_b;
        if (i_cmd.start_query) begin
            n_lo_a  = '0;
            n_end_a = n_eff;
            n_lo_b  = '0;
            n_end_b = n_eff;
        end else if (i_cmd.step) begin
            if (!done_a) begin
                if (hit_a) begin
                    n_end_a = mid_a;
                end else begin
                    n_lo_a = mid_a + CNT_W'(1);
                end
            end
            if (!done_b) begin
                if (hit_b) begin
                    n_end_b = mid_b;
                end else begin
                    n_lo_b = mid_b + CNT_W'(1);
                end
            end
        end
    end

    // next probe address, read into the store read register ahead of the compare
    assign nsum_a = {1'b0, n_lo_a} + {1'b0, n_end_a} - (CNT_W + 1)'(1);
    assign nsum_b = {1'b0, n_lo_b} + {1'b0, n_end_b} - (CNT_W + 1)'(1);
    assign nmid_a = nsum_a[CNT_W:1];
    assign nmid_b = nsum_b[CNT_W:1];

    always_ff @(posedge i_clk) begin
        r_lo_a  <= n_lo_a;
        r_end_a <= n_end_a;
        r_lo_b  <= n_lo_b;
        r_end_b <= n_end_b;
        if (i_cmd.start_query) begin
            r_key_lo <= i_query_low;
            r_key_hi <= i_query_high;
        end
    end

    // result register: upper bound index minus lower bound index
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result <= srcs_pkg::RES_W'(r_end_b) - srcs_pkg::RES_W'(r_end_a);
        end
    end

    assign o_status.search_done = done_a && done_b;
    assign o_points_inside      = r_result;

    // search intervals never invert while probing
    a_interval_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_lo_a <= r_end_a) && (r_lo_b <= r_end_b))
        else $error("search interval inverted");

    // each probe of the open lower bound search narrows its interval
    a_lower_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && !done_a |=>
            (r_lo_a != $past(r_lo_a)) || (r_end_a != $past(r_end_a)))
        else $error("lower bound search made no progress");

    // bounds never pass the effective point count
    a_bound_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_end_a <= n_eff) && (r_end_b <= n_eff))
        else $error("search bound beyond point count");

endmodule

// ===== hw/rtl/sorted_range_count_search.sv =====
// Sorted range count search. Load requests (mode 0) write one signed point into the
// store; the points must be loaded in ascending order and point_count set (through the
// write-only config port, while idle) to the number of points the searches cover,
// saturated to MAX_POINTS. A query request (mode 1) runs a lower-bound search for
// query_low and an upper-bound search for query_high side by side, one probe per cycle
// on the two read ports of the point store, and returns upper minus lower index as a
// 12-bit signed count. The longer search takes at most floor(log2(point_count)) + 1
// probes, and the block takes no new request until the query has finished. A finished
// result waits in the output register while the next request is accepted. The store
// has no reset: only entries that were loaded may be searched.
// depends on srcs_pkg, srcs_ctrl, srcs_dp and srcs_ram
module sorted_range_count_search #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srcs_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic [srcs_pkg::IDX_W-1:0]        i_load_index,
    input  logic signed [srcs_pkg::VAL_W-1:0] i_load_value,
    input  logic signed [srcs_pkg::VAL_W-1:0] i_query_low,
    input  logic signed [srcs_pkg::VAL_W-1:0] i_query_high,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [srcs_pkg::RES_W-1:0] o_points_inside
);

    srcs_pkg::t_cmd    cmd;
    srcs_pkg::t_status status;

    // sequencing and handshakes
    srcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // store, searches and result
    srcs_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_load_index    (i_load_index),
        .i_load_value    (i_load_value),
        .i_query_low     (i_query_low),
        .i_query_high    (i_query_high),
        .o_points_inside (o_points_inside)
    );

endmodule

// ===== test/sorted_range_count_search_tb.sv =====
// testbench for sorted_range_count_search: loads sorted point sets, sets point_count
// and checks every segment count against a predictor kept inside this file or a count typed into the plan
// depends on srcs_pkg and sorted_range_count_search
`timescale 1ns / 100ps

module sorted_range_count_search_tb;

    localparam int CFG_W = srcs_pkg::CFG_W;
    localparam int IDX_W = srcs_pkg::IDX_W;
    localparam int VAL_W = srcs_pkg::VAL_W;
    localparam int RES_W = srcs_pkg::RES_W;

    localparam int MAX_POINTS   = 1024;
    localparam int DRAIN_CYCLES = 20;    // idle wait after the last count has come back
    localparam int QUIET_LIMIT  = 4000;  // cycles without any transfer before giving up
    localparam int RANDOM_ITEMS = 50;
    localparam int STEADY_FROM  = 600;   // full store loads from here on run with no idling

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // kinds of rows in the directed plan
    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY,
        ROW_COUNT
    } t_row_kind;

    // load: a = index, b = value; query: a = low, b = high; count: a = point_count
    typedef struct packed {
        t_row_kind kind;
        int        arg_a;
        int        arg_b;
        bit        typed;
        int        want;
    } t_row;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     cfg_we       = 1'b0;
    logic [CFG_W-1:0]         cfg_wdata    = '0;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    logic                     req_mode     = srcs_pkg::MODE_LOAD;
    logic [IDX_W-1:0]         req_index    = '0;
    logic signed [VAL_W-1:0]  req_value    = '0;
    logic signed [VAL_W-1:0]  req_low      = '0;
    logic signed [VAL_W-1:0]  req_high     = '0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    logic signed [RES_W-1:0]  points_inside;

    // predictor state
    logic signed [VAL_W-1:0]  point_copy [MAX_POINTS];
    int                       cover_count = 0;
    logic signed [RES_W-1:0]  counts_due [$];

    int  faults      = 0;
    int  quiet       = 0;
    int  items_done  = 0;
    bit  steady      = 1'b0;   // no idling on either side while set
    logic signed [RES_W-1:0] got_want;

    // directed plan: empty store, extremes, duplicates, reversed and unsorted cases
    t_row plan [0:22] = '{
        '{ROW_QUERY, VAL_MIN, VAL_MAX, 1'b1, 0},   // empty store
        '{ROW_QUERY, VAL_MAX, VAL_MIN, 1'b1, 0},
        '{ROW_LOAD,  0,       VAL_MIN, 1'b0, 0},
        '{ROW_LOAD,  1,       -5,      1'b0, 0},
        '{ROW_LOAD,  2,       0,       1'b0, 0},
        '{ROW_LOAD,  3,       7,       1'b0, 0},
        '{ROW_LOAD,  4,       7,       1'b0, 0},
        '{ROW_LOAD,  5,       VAL_MAX, 1'b0, 0},
        '{ROW_LOAD,  1023,    VAL_MAX, 1'b0, 0},
        '{ROW_COUNT, 6,       0,       1'b0, 0},
        '{ROW_QUERY, VAL_MIN, VAL_MAX, 1'b1, 6},   // whole range
        '{ROW_QUERY, VAL_MAX, VAL_MIN, 1'b1, -4},  // reversed segment goes negative
        '{ROW_QUERY, 7,       7,       1'b1, 2},   // duplicate points
        '{ROW_QUERY, 1,       6,       1'b1, 0},   // gap between points
        '{ROW_QUERY, -5,      0,       1'b0, 0},
        '{ROW_QUERY, VAL_MIN, VAL_MIN, 1'b1, 1},
        '{ROW_QUERY, VAL_MAX, VAL_MAX, 1'b1, 1},
        '{ROW_COUNT, 1,       0,       1'b0, 0},
        '{ROW_QUERY, VAL_MIN, VAL_MAX, 1'b1, 1},
        '{ROW_LOAD,  2,       -100,    1'b0, 0},   // breaks the ascending order
        '{ROW_COUNT, 6,       0,       1'b0, 0},
        '{ROW_QUERY, -100,    -100,    1'b0, 0},
        '{ROW_QUERY, -6,      6,       1'b0, 0}
    };

    sorted_range_count_search uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (req_mode),
        .i_load_index    (req_index),
        .i_load_value    (req_value),
        .i_query_low     (req_low),
        .i_query_high    (req_high),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_points_inside (points_inside)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // first index below span whose point passes the test, span if none
    function automatic int bound_index(input int span, input logic signed [VAL_W-1:0] key,
                                       input bit strict);
        int lo;
        int hi;
        int mid;
        int found;
        bit hit;
        lo    = 0;
        hi    = span - 1;
        found = span;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            hit = strict ? (point_copy[mid] > key) : (point_copy[mid] >= key);
            if (hit) begin
                found = mid;
                hi    = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return found;
    endfunction

    // points between low and high under the current point_count
    function automatic logic signed [RES_W-1:0] count_between(
        input logic signed [VAL_W-1:0] low, input logic signed [VAL_W-1:0] high);
        int span;
        span = (cover_count > MAX_POINTS) ? MAX_POINTS : cover_count;
        return RES_W'(bound_index(span, high, 1'b1) - bound_index(span, low, 1'b0));
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_value(input longint v);
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        return v[VAL_W-1:0];
    endfunction

    // key near a stored point most of the time, anywhere otherwise
    function automatic logic signed [VAL_W-1:0] pick_key(input int span);
        longint near;
        if (span == 0 || $urandom_range(0, 99) < 20)
            return $urandom;
        near = longint'(point_copy[$urandom_range(0, span - 1)]);
        return clamp_value(near + $urandom_range(0, 4) - 2);
    endfunction

    // send one request, predict it at the edge where it is taken
    task automatic send_request(input logic mode, input logic [IDX_W-1:0] index,
                                input logic signed [VAL_W-1:0] value,
                                input logic signed [VAL_W-1:0] low,
                                input logic signed [VAL_W-1:0] high,
                                input bit typed, input int want);
        if (!steady && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        req_mode  <= mode;
        req_index <= index;
        req_value <= value;
        req_low   <= low;
        req_high  <= high;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (mode == srcs_pkg::MODE_LOAD)
            point_copy[index] = value;
        else if (typed)
            counts_due.push_back(RES_W'(want));
        else
            counts_due.push_back(count_between(low, high));
    endtask

    task automatic send_load(input logic [IDX_W-1:0] index, input logic signed [VAL_W-1:0] value);
        send_request(srcs_pkg::MODE_LOAD, index, value, $urandom, $urandom, 1'b0, 0);
    endtask

    task automatic send_query(input logic signed [VAL_W-1:0] low,
                              input logic signed [VAL_W-1:0] high);
        send_request(srcs_pkg::MODE_QUERY, IDX_W'($urandom), $urandom, low, high, 1'b0, 0);
    endtask

    // let every pending count come back and the block go quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (counts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] count);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        cover_count = int'(count);
    endtask

    // query mostly well-formed segments, a quarter of crossed keys stay reversed
    task automatic random_query(input int span);
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        a = pick_key(span);
        b = pick_key(span);
        if (a > b && $urandom_range(0, 99) < 75)
            send_query(b, a);
        else
            send_query(a, b);
    endtask

    // result side: random back-pressure
    always @(posedge i_clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= 9);
    end

    // compare each count with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (counts_due.size() == 0) begin
                $display("%0t: unexpected count, expected none actual %0d",
                         $time, points_inside);
                faults++;
            end else begin
                got_want = counts_due.pop_front();
                if (points_inside !== got_want) begin
                    $display("%0t: points_inside mismatch, expected %0d actual %0d",
                             $time, got_want, points_inside);
                    faults++;
                end
            end
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !i_rst_n) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        int span;
        int rounds;
        int idx;
        longint level;
        longint stride;
        logic signed [VAL_W-1:0] prev;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan
        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_LOAD: begin
                    send_load(IDX_W'(plan[r].arg_a), plan[r].arg_b);
                end
                ROW_QUERY: begin
                    send_request(srcs_pkg::MODE_QUERY, IDX_W'($urandom), $urandom,
                                 plan[r].arg_a, plan[r].arg_b, plan[r].typed,
                                 plan[r].want);
                end
                default: begin
                    write_count(CFG_W'(plan[r].arg_a));
                end
            endcase
        end

        // full store: ascending points over the whole value range, some repeated
        prev = VAL_MIN;
        for (int i = 0; i < MAX_POINTS; i++) begin
            steady = (i >= STEADY_FROM);
            if (i > 0 && $urandom_range(0, 7) == 0)
                send_load(IDX_W'(i), prev);
            else begin
                prev = clamp_value(longint'(VAL_MIN) + longint'(i) * 64'd4194304
                                   + $urandom_range(0, 4194303));
                send_load(IDX_W'(i), prev);
            end
        end
        write_count(CFG_W'(MAX_POINTS));
        repeat (15) random_query(MAX_POINTS);
        steady = 1'b0;
        write_count({CFG_W{1'b1}});          // saturates to the store size
        repeat (5) random_query(MAX_POINTS);
        write_count(CFG_W'(MAX_POINTS + 1));
        repeat (5) random_query(MAX_POINTS);

        // random phases: load a sorted set, set the count, then mostly queries
        while (items_done < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1:    span = 0;
                2, 3:    span = 1;
                4:       span = $urandom_range(41, 64);
                default: span = $urandom_range(2, 40);
            endcase

            if ($urandom_range(0, 99) < 30) begin
                stride = 64'h1_0000_0000 / (span + 1);
                level  = longint'(VAL_MIN) + $urandom_range(0, 32'(stride - 1));
            end else begin
                stride = $urandom_range(1, 4);
                level  = longint'($signed($urandom));
            end
            for (int i = 0; i < span; i++) begin
                send_load(IDX_W'(i), clamp_value(level));
                level = level + $urandom_range(0, 32'(stride - 1));
                items_done++;
            end
            write_count(CFG_W'(span));

            rounds = $urandom_range(8, 30);
            for (int k = 0; k < rounds; k++) begin
                if ($urandom_range(0, 99) < 85) begin
                    random_query(span);
                end else begin
                    // overwrite inside the count (unsorted) or park a point beyond it
                    if (span > 0 && $urandom_range(0, 1) == 0)
                        idx = $urandom_range(0, span - 1);
                    else
                        idx = $urandom_range(span, MAX_POINTS - 1);
                    send_load(IDX_W'(idx), $urandom);
                end
                items_done++;
            end
        end

        // wait for the last counts, then a little longer for stray ones
        drain();
        if (faults == 0 && counts_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
